### hw/rtl/gmcs_pkg.sv
// Package: shared types and constants for the gamepad motion command shaper.
package gmcs_pkg;
    localparam int QONE = 16384;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic [1:0] LIFT_STOP = 2'd0;
    localparam logic [1:0] LIFT_UP   = 2'd1;
    localparam logic [1:0] LIFT_DOWN = 2'd2;
    localparam logic [1:0] LIFT_HOME = 2'd3;
    localparam logic [1:0] REG_DEADZONE = 2'd0;
    localparam logic [1:0] REG_GEARS    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  buttons;
        logic signed [15:0] stick_fwd;
        logic signed [15:0] stick_turn;
        logic signed [15:0] trig_slow;
        logic signed [15:0] trig_fast;
        logic signed [15:0] dpad_fwd;
        logic signed [15:0] dpad_turn;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  lift_cmd;
        logic signed [15:0] linear_out;
        logic signed [15:0] angular_out;
        logic [7:0]  gear_out;
        logic        estop_out;
        logic        priority_out;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, do button/flag update
        logic div_start; // start deadzone division on axis sel
        logic axis_sel;  // 0 fwd, 1 turn
        logic mul_a;     // speed factor product step
        logic mul_b;     // stick times factor step
        logic fin;       // final target select
        logic emit;      // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_tick;
    } dp_sts_t;

    function automatic logic signed [15:0] sat_axis(input logic signed [15:0] v);
        if (v > 16'sd16384) return 16'sd16384;
        if (v < -16'sd16384) return -16'sd16384;
        return v;
    endfunction
endpackage

### hw/rtl/gmcs_if.sv
// Interfaces: input and result request channels.
interface gmcs_in_if;
    import gmcs_pkg::*;
    logic valid;
    logic ready;
    in_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface gmcs_out_if;
    import gmcs_pkg::*;
    logic valid;
    logic ready;
    out_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/gamepad_motion_command_shaper.sv
// A sample request runs two deadzone divisions in turn before its result is valid; a
// tick request goes straight to its result. One request at a time; the next is taken
// only after the result is accepted and the controller is back in idle.
// Reset (rst_n, asynchronous, active low): registers at default values,
// gear 10, flags and targets zero, first sample pending.
module gamepad_motion_command_shaper (
    input  logic        clk,
    input  logic        rst_n,
    gmcs_in_if.sink     in_ch,
    gmcs_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gmcs_pkg::*;
    logic [13:0] dz_reg;
    logic [7:0]  gc_reg;
    logic [15:0] to_reg;
    logic        wr;
    logic [1:0]  idx;
    dp_cmd_t cmd;
    dp_sts_t sts;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= 14'd1638;
            gc_reg <= 8'd20;
            to_reg <= 16'd25;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_DEADZONE: dz_reg <= pwdata[13:0];
                REG_GEARS:    gc_reg <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
                REG_TIMEOUT:  to_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEADZONE: prdata = {18'd0, dz_reg};
            REG_GEARS:    prdata = {24'd0, gc_reg};
            REG_TIMEOUT:  prdata = {16'd0, to_reg};
            default:      prdata = '0;
        endcase
    end

    logic [7:0] gc_wr;
    assign gc_wr = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];

    gmcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .in_opcode(in_ch.data.opcode), .sts(sts), .cmd(cmd)
    );

    gmcs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .item(in_ch.data),
        .deadzone(dz_reg), .gear_count((wr && idx == REG_GEARS) ? gc_wr : gc_reg),
        .timeout_ticks(to_reg), .gear_load(wr && idx == REG_GEARS),
        .result(out_ch.data)
    );

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_tick_lift: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.result_kind) |-> out_ch.data.lift_cmd == LIFT_STOP)
        else $error("tick result with lift command");
    a_gear_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.gear_out != 8'd0) else $error("gear zero");
endmodule

### hw/rtl/gmcs_div.sv
// Restoring divider: 29-bit dividend by 15-bit divisor, one quotient bit a cycle.
module gmcs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [28:0] dividend,
    input  logic [14:0] divisor,
    output logic        done,
    output logic [28:0] quotient
);
    logic [28:0] q_reg, q_next;
    logic [15:0] r_reg, r_next;
    logic [14:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [15:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[14:0], q_reg[28]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 5'd29;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[27:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[27:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && cnt_reg == 5'd1;
    assign quotient = q_next;
endmodule

### hw/rtl/gmcs_datapath.sv
// Datapath: state registers, deadzone, speed factor, d-pad and output register.
module gmcs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gmcs_pkg::dp_cmd_t    cmd,
    output gmcs_pkg::dp_sts_t    sts,
    input  gmcs_pkg::in_item_t   item,
    input  logic [13:0]          deadzone,
    input  logic [7:0]           gear_count,
    input  logic [15:0]          timeout_ticks,
    input  logic                 gear_load,
    output gmcs_pkg::out_item_t  result
);
    import gmcs_pkg::*;

    in_item_t    it_reg;
    logic [6:0]  prev_reg;
    logic        first_reg, estop_reg, prio_reg;
    logic [7:0]  gear_reg;
    logic signed [15:0] tlin_reg, tang_reg;
    logic [15:0] idle_reg;
    logic signed [15:0] db_reg [2];
    logic [35:0] mfull_reg;
    logic signed [15:0] lin_reg, ang_reg;
    out_item_t   res_reg;

    logic [6:0]  rise;
    logic signed [15:0] ax;
    logic [14:0] mag;
    logic        div_done;
    logic [28:0] quo;
    logic [7:0]  gnext;

    // divider operand: selected stick axis magnitude above deadzone
    always_comb
    begin
        ax = sat_axis(it_reg.stick_turn);
        if (!cmd.axis_sel)
            ax = sat_axis(it_reg.stick_fwd);
        mag = ax[15] ? 15'(-ax) : ax[14:0];
    end

    logic [14:0] over;
    assign over = mag - {1'b0, deadzone};

    gmcs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend({over, 14'd0}), .divisor(15'(QONE) - {1'b0, deadzone}),
        .done(div_done), .quotient(quo)
    );

    assign sts.div_done = div_done;
    assign sts.is_tick = it_reg.opcode == OP_TICK;

    // speed factor: S in [98304,327680], F in [65536,98304]
    logic signed [15:0] ts, tf;
    logic [18:0] s_val;
    logic [17:0] f_val;
    assign ts = sat_axis(it_reg.trig_slow);
    assign tf = sat_axis(it_reg.trig_fast);
    assign s_val = 19'(20 * QONE) - 19'(7 * (32'(QONE) - 32'(signed'(ts))));
    assign f_val = 18'(4 * QONE) + 18'(32'(QONE) - 32'(signed'(tf)));

    // stick * m / (80*2^28); m < 2^35, split stick*m into two 18x16 products
    logic signed [15:0] sv;
    logic [15:0] sm;
    logic [53:0] prod_lo, prod_hi;
    logic [52:0] pacc_reg;
    assign sv = db_reg[cmd.axis_sel];
    assign sm = sv[15] ? 16'(-sv) : 16'(sv);
    assign prod_lo = 54'(mfull_reg[17:0]) * 54'(sm);
    assign prod_hi = 54'(mfull_reg[35:18]) * 54'(sm);

    // divide |stick*m| by 80*2^28: shift 32, then /5 by reciprocal multiply
    logic [20:0] sh;
    logic [20:0] qd;
    assign sh = 21'(pacc_reg >> 32);
    assign qd = 21'((42'(sh) * 42'(26215)) >> 17);
    logic [20:0] q5;
    always_comb
    begin
        q5 = qd;
        if (21'(qd * 21'd5) > sh)
            q5 = qd - 21'd1;
        else if (21'((qd + 21'd1) * 21'd5) <= sh)
            q5 = qd + 21'd1;
    end
    logic signed [15:0] clamped;
    assign clamped = (q5 > 21'd16384) ? (sv[15] ? -16'sd16384 : 16'sd16384)
                   : (sv[15] ? -16'(q5) : 16'(q5));

    // d-pad gains: magnitude /10 by reciprocal multiply, exact below 2^18
    logic signed [15:0] dy, dx;
    logic [15:0] ady, adx;
    logic [16:0] ay2, ax3;
    logic [16:0] qy, qx;
    logic signed [17:0] dy2, dx3;
    assign dy = sat_axis(it_reg.dpad_fwd);
    assign dx = sat_axis(it_reg.dpad_turn);
    assign ady = dy[15] ? 16'(-dy) : 16'(dy);
    assign adx = dx[15] ? 16'(-dx) : 16'(dx);
    assign ay2 = {ady, 1'b0};
    assign ax3 = 17'({1'b0, adx} * 17'd3);
    assign qy = 17'((34'(ay2) * 34'd52429) >> 19);
    assign qx = 17'((34'(ax3) * 34'd52429) >> 19);
    assign dy2 = dy[15] ? -18'(qy) : 18'(qy);
    assign dx3 = dx[15] ? 18'(qx) : -18'(qx);

    assign rise = item.buttons & ~(first_reg ? item.buttons : prev_reg);
    always_comb
    begin
        gnext = gear_reg;
        if (rise[2] && gear_reg > 8'd1)
            gnext = gear_reg - 8'd1;
        if (rise[3])
            gnext = (gnext >= gear_count) ? gear_count : gnext + 8'd1;
    end

    logic estop_new;
    assign estop_new = estop_reg ^ rise[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            first_reg <= 1'b1;
            estop_reg <= 1'b0;
            prio_reg <= 1'b0;
            gear_reg <= 8'd10;
            tlin_reg <= '0;
            tang_reg <= '0;
            idle_reg <= '0;
        end
        else
        begin
            if (gear_load)
                gear_reg <= (gear_count[7:1] == 7'd0) ? 8'd1 : {1'b0, gear_count[7:1]};
            if (cmd.load)
            begin
                if (item.opcode == OP_SAMPLE)
                begin
                    prev_reg <= item.buttons;
                    first_reg <= 1'b0;
                    estop_reg <= estop_new;
                    prio_reg <= prio_reg ^ rise[1];
                    gear_reg <= gnext;
                    idle_reg <= '0;
                    if (estop_new)
                    begin
                        tlin_reg <= '0;
                        tang_reg <= '0;
                    end
                end
                else if (idle_reg != 16'hFFFF)
                    idle_reg <= idle_reg + 16'd1;
            end
            if (cmd.fin && cmd.axis_sel && !estop_reg)
            begin
                if (ady > 16'd8192 || adx > 16'd8192)
                begin
                    tlin_reg <= 16'(dy2);
                    tang_reg <= 16'(dx3);
                end
                else
                begin
                    tlin_reg <= lin_reg;
                    tang_reg <= clamped;
                end
            end
        end
    end

    logic [1:0] lift;
    always_comb
    begin
        priority if (it_reg.buttons[4]) lift = LIFT_UP;
        else if (it_reg.buttons[5])     lift = LIFT_DOWN;
        else if (res_reg.lift_cmd == LIFT_HOME) lift = LIFT_HOME;
        else                            lift = LIFT_STOP;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= item;
            res_reg.lift_cmd <= rise[6] ? LIFT_HOME : LIFT_STOP;
        end
        if (div_done)
        begin
            if (mag < {1'b0, deadzone})
                db_reg[cmd.axis_sel] <= '0;
            else
                db_reg[cmd.axis_sel] <= ax[15] ? -16'(quo) : 16'(quo);
        end
        if (cmd.mul_a)
            mfull_reg <= 36'(s_val) * 36'(f_val);
        if (cmd.mul_b)
            pacc_reg <= 53'(prod_lo) + 53'({prod_hi, 18'd0});
        if (cmd.fin)
        begin
            if (cmd.axis_sel)
                ang_reg <= clamped;
            else
                lin_reg <= clamped;
        end
        if (cmd.emit)
        begin
            res_reg.result_kind <= it_reg.opcode;
            res_reg.gear_out <= gear_reg;
            res_reg.estop_out <= estop_reg;
            res_reg.priority_out <= prio_reg;
            if (it_reg.opcode == OP_TICK)
            begin
                res_reg.lift_cmd <= LIFT_STOP;
                res_reg.linear_out <= (idle_reg <= timeout_ticks) ? tlin_reg : '0;
                res_reg.angular_out <= (idle_reg <= timeout_ticks) ? tang_reg : '0;
            end
            else
            begin
                res_reg.lift_cmd <= lift;
                res_reg.linear_out <= '0;
                res_reg.angular_out <= '0;
            end
        end
    end

    assign result = res_reg;
endmodule

### hw/rtl/gmcs_ctrl.sv
// Controller: sequences load, divisions, products, target update and result.
module gmcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               in_opcode,
    input  gmcs_pkg::dp_sts_t  sts,
    output gmcs_pkg::dp_cmd_t  cmd
);
    import gmcs_pkg::*;
    typedef enum logic [3:0] {
        S_IDLE, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_MULA,
        S_MB0, S_FIN0, S_MB1, S_FIN1, S_EMIT, S_OUT
    } state_t;
    state_t state_reg;
    logic   ov_reg;
    logic   take;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign take = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = take;
        unique case (state_reg)
            S_DIV0:  cmd.div_start = 1'b1;
            S_WAIT0: cmd.axis_sel = 1'b0;
            S_DIV1:  begin cmd.div_start = 1'b1; cmd.axis_sel = 1'b1; end
            S_WAIT1: cmd.axis_sel = 1'b1;
            S_MULA:  cmd.mul_a = 1'b1;
            S_MB0:   cmd.mul_b = 1'b1;
            S_FIN0:  cmd.fin = 1'b1;
            S_MB1:   begin cmd.mul_b = 1'b1; cmd.axis_sel = 1'b1; end
            S_FIN1:  begin cmd.fin = 1'b1; cmd.axis_sel = 1'b1; end
            S_EMIT:  cmd.emit = 1'b1;
            default: cmd.load = take;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (take) state_reg <= (in_opcode == OP_TICK) ? S_EMIT : S_DIV0;
                S_DIV0:  state_reg <= S_WAIT0;
                S_WAIT0: if (sts.div_done) state_reg <= S_DIV1;
                S_DIV1:  state_reg <= S_WAIT1;
                S_WAIT1: if (sts.div_done) state_reg <= S_MULA;
                S_MULA:  state_reg <= S_MB0;
                S_MB0:   state_reg <= S_FIN0;
                S_FIN0:  state_reg <= S_MB1;
                S_MB1:   state_reg <= S_FIN1;
                S_FIN1:  state_reg <= S_EMIT;
                S_EMIT:  begin state_reg <= S_OUT; ov_reg <= 1'b1; end
                S_OUT:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
